[hdl/pmi_pkg.sv]
`default_nettype none

package pmi_pkg;

  // Field width of operand and inverse.
  localparam int unsigned VAL_W = 30;

  // The prime modulus and values derived from it.
  localparam logic [VAL_W-1:0] PRIME      = 30'd1000000007;
  localparam logic [31:0]      TWO_PRIME  = 32'd2000000014;
  localparam logic [VAL_W-1:0] FERMAT_EXP = 30'd1000000005;

  // Barrett constant floor(2^60 / PRIME), used with a 28-bit pre-shift
  // and a 32-bit post-shift of the product.
  localparam logic [30:0] BARRETT_M = 31'd1152921496;

  // One cell per exponent bit, five register stages per modular multiply.
  localparam int unsigned NUM_CELLS  = VAL_W;
  localparam int unsigned MUL_STAGES = 5;

  // What one cell hands to the next in every cycle.
  typedef struct packed {
    logic             valid;
    logic [VAL_W-1:0] base;
    logic [VAL_W-1:0] acc;
  } pmi_beat_t;

endpackage : pmi_pkg

`default_nettype wire

[hdl/pmi_modmul.sv]
`default_nettype none

module pmi_modmul (
  input  wire logic                      clk,
  input  wire logic                      adv,
  input  wire logic [pmi_pkg::VAL_W-1:0] a,
  input  wire logic [pmi_pkg::VAL_W-1:0] b,
  output logic      [pmi_pkg::VAL_W-1:0] r
);
  import pmi_pkg::*;

  logic [59:0] prod;
  logic [62:0] q_full;
  logic [29:0] q;
  logic [31:0] lo2;
  logic [59:0] qp_full;
  logic [31:0] qp;
  logic [31:0] lo3;
  logic [31:0] rem;
  logic [31:0] rem_m1;
  logic [31:0] rem_m2;

  // The quotient estimate is at most two below the true quotient, so the
  // remainder stays below three times the prime and fits in 32 bits.
  assign q_full  = prod[59:28] * BARRETT_M;
  assign qp_full = q * PRIME;
  assign rem_m1  = rem - {2'b00, PRIME};
  assign rem_m2  = rem - TWO_PRIME;

  // Product, quotient estimate, quotient times prime, raw remainder, fix-up.
  always_ff @(posedge clk) begin
    if (adv) begin
      prod <= a * b;
      q    <= q_full[61:32];
      lo2  <= prod[31:0];
      qp   <= qp_full[31:0];
      lo3  <= lo2;
      rem  <= lo3 - qp;
      if (rem >= TWO_PRIME) begin
        r <= rem_m2[VAL_W-1:0];
      end else if (rem >= {2'b00, PRIME}) begin
        r <= rem_m1[VAL_W-1:0];
      end else begin
        r <= rem[VAL_W-1:0];
      end
    end
  end

endmodule : pmi_modmul

`default_nettype wire

[hdl/pmi_cell.sv]
`default_nettype none

module pmi_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               adv,
  input  wire logic               exp_bit,
  input  wire pmi_pkg::pmi_beat_t beat_in,
  output pmi_pkg::pmi_beat_t      beat_out
);
  import pmi_pkg::*;

  logic [MUL_STAGES-1:0] vld;
  logic [VAL_W-1:0]      acc_factor;

  // The accumulator takes the base only where this exponent bit is set.
  assign acc_factor = exp_bit ? beat_in.base : {{(VAL_W-1){1'b0}}, 1'b1};

  pmi_modmul u_square (
    .clk (clk),
    .adv (adv),
    .a   (beat_in.base),
    .b   (beat_in.base),
    .r   (beat_out.base)
  );

  pmi_modmul u_acc (
    .clk (clk),
    .adv (adv),
    .a   (beat_in.acc),
    .b   (acc_factor),
    .r   (beat_out.acc)
  );

  // Valid bits travel alongside the multiplier stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[MUL_STAGES-2:0], beat_in.valid};
    end
  end

  assign beat_out.valid = vld[MUL_STAGES-1];

  // A held chain keeps every beat in place.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld))
    else $error("cell valid bits moved while the chain was held");

  // Both products leave the cell fully reduced.
  a_reduced: assert property (@(posedge clk) disable iff (rst)
    beat_out.valid |-> (beat_out.base < PRIME) && (beat_out.acc < PRIME))
    else $error("cell output not reduced modulo the prime");

endmodule : pmi_cell

`default_nettype wire

[hdl/prime_modular_inverse_unit.sv]
`default_nettype none

// Channel   Signals                                   Beat payload
// -------   ---------------------------------------   ----------------------------
// input     operand_valid, operand_ready, operand     30-bit value to invert
// output    inverse_valid, inverse_ready, inverse     30-bit inverse mod 1000000007
//
// An accepted beat passes through one input reduction stage, thirty cells
// of five multiplier stages each, and the output register before its result
// shows. One beat enters per cycle while the output is taken.
// Reset clears only the valid bits; no clearing pass is needed.
// A stalled output holds the whole chain once its last stage is occupied.

module prime_modular_inverse_unit (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      operand_valid,
  output logic                           operand_ready,
  input  wire logic [pmi_pkg::VAL_W-1:0] operand,
  output logic                           inverse_valid,
  input  wire logic                      inverse_ready,
  output logic      [pmi_pkg::VAL_W-1:0] inverse
);
  import pmi_pkg::*;

  pmi_beat_t        head;
  pmi_beat_t        chain [NUM_CELLS+1];
  logic             adv;
  logic [VAL_W-1:0] operand_red;
  logic             last_valid;

  assign last_valid = chain[NUM_CELLS].valid;

  // The chain moves unless its last beat has nowhere to go.
  assign adv           = !last_valid || !inverse_valid || inverse_ready;
  assign operand_ready = adv;

  // The operand is below twice the prime, so one subtract reduces it.
  assign operand_red = (operand >= PRIME) ? (operand - PRIME) : operand;

  // Input stage: the valid bit is reset, the payload only moves with the chain.
  always_ff @(posedge clk) begin
    if (rst) begin
      head.valid <= 1'b0;
    end else if (adv) begin
      head.valid <= operand_valid;
    end
    if (adv) begin
      head.base <= operand_red;
      head.acc  <= {{(VAL_W-1){1'b0}}, 1'b1};
    end
  end

  assign chain[0] = head;

  // One cell per exponent bit, least significant bit first.
  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    pmi_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .exp_bit  (FERMAT_EXP[k]),
      .beat_in  (chain[k]),
      .beat_out (chain[k+1])
    );
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      inverse_valid <= 1'b0;
    end else if (inverse_ready || !inverse_valid) begin
      inverse_valid <= last_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && last_valid) begin
      inverse <= chain[NUM_CELLS].acc;
    end
  end

  // A shown result is always a residue.
  a_range: assert property (@(posedge clk) disable iff (rst)
    inverse_valid |-> (inverse < PRIME))
    else $error("inverse out of range");

  // A new result comes only from a beat at the end of the chain.
  a_source: assert property (@(posedge clk) disable iff (rst)
    $rose(inverse_valid) |-> $past(last_valid))
    else $error("result appeared without a beat at the end of the chain");

endmodule : prime_modular_inverse_unit

`default_nettype wire

[bench/tb_prime_modular_inverse_unit.sv]
`timescale 1ns / 100ps

module tb_prime_modular_inverse_unit;

  localparam int unsigned W = pmi_pkg::VAL_W;

  // Modulus and exponent for the inverse computation.
  localparam logic [63:0] MODULUS = 64'd1000000007;
  localparam logic [31:0] FERMAT_POWER = 32'd1000000005;
  localparam logic [W-1:0] PRIME_VAL = 30'd1000000007;
  localparam logic [W-1:0] TOP_VAL = 30'h3FFFFFFF;

  // Cycle budget and drain tail after the last result.
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 160;
  localparam int unsigned MAX_PRINTED = 20;
  localparam int unsigned RANDOM_PER_PHASE = 300;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         operand_valid = 1'b0;
  logic         operand_ready;
  logic [W-1:0] operand = '0;
  logic         inverse_valid;
  logic         inverse_ready = 1'b0;
  logic [W-1:0] inverse;

  logic [W-1:0] pending_operands[$];
  logic [W-1:0] expected_operands[$];
  logic [W-1:0] expected_inverses[$];

  int unsigned sender_idle_pct = 22;
  int unsigned receiver_idle_pct = 71;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  prime_modular_inverse_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .operand_valid (operand_valid),
    .operand_ready (operand_ready),
    .operand       (operand),
    .inverse_valid (inverse_valid),
    .inverse_ready (inverse_ready),
    .inverse       (inverse)
  );

  always #10 clk = ~clk;

  // Raise the value to p-2 modulo p by square-and-multiply.
  function automatic logic [W-1:0] fermat_inverse_of(input logic [W-1:0] value);
    logic [63:0] base;
    logic [63:0] acc;
    logic [31:0] e;
    base = {34'd0, value} % MODULUS;
    acc = 64'd1;
    e = FERMAT_POWER;
    while (e != 32'd0) begin
      if (e[0]) begin
        acc = (acc * base) % MODULUS;
      end
      base = (base * base) % MODULUS;
      e = e >> 1;
    end
    return acc[W-1:0];
  endfunction

  // Random operand: near the modulus, small, above the modulus, or any 30-bit value.
  function automatic logic [W-1:0] random_operand();
    logic [W-1:0] value;
    case ($urandom_range(9))
      0: value = PRIME_VAL - 30'd8 + W'($urandom_range(16));
      1: value = W'($urandom_range(255));
      2, 3: value = W'($urandom_range(1073741823, 1000000007));
      default: value = W'($urandom);
    endcase
    return value;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTED) begin
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
    end
    mismatch_count++;
  endtask

  // Append one operand to the list the driver draws from.
  task automatic queue_operand(input logic [W-1:0] value);
    pending_operands = {pending_operands, value};
  endtask

  // Wait until every queued operand is sent and every result has arrived.
  task automatic wait_drained();
    while (pending_operands.size() != 0 || operand_valid || expected_inverses.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Driver: record accepted beats and present the next pending operand.
  always @(posedge clk) begin
    if (rst) begin
      operand_valid <= 1'b0;
    end else begin
      if (operand_valid && operand_ready) begin
        expected_operands = {expected_operands, operand};
        expected_inverses = {expected_inverses, fermat_inverse_of(operand)};
      end
      if (!operand_valid || operand_ready) begin
        if (pending_operands.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          operand_valid <= 1'b1;
          operand <= pending_operands.pop_front();
        end else begin
          operand_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result beat with the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      inverse_ready <= 1'b0;
    end else begin
      if (inverse_valid && inverse_ready) begin
        if (expected_inverses.size() == 0) begin
          report_mismatch($sformatf("unexpected result %0d", inverse));
        end else begin
          if (inverse !== expected_inverses[0]) begin
            report_mismatch($sformatf("operand %0d: inverse %0d, expected %0d",
                                      expected_operands[0], inverse, expected_inverses[0]));
          end
          void'(expected_inverses.pop_front());
          void'(expected_operands.pop_front());
        end
      end
      inverse_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Stimulus: directed operands, then three random phases with different idling.
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Extremes, values around the modulus, and both zero-congruent operands.
    queue_operand(30'd0);
    queue_operand(30'd1);
    queue_operand(30'd2);
    queue_operand(30'd3);
    queue_operand(30'd500000004);
    queue_operand(PRIME_VAL - 30'd2);
    queue_operand(PRIME_VAL - 30'd1);
    queue_operand(PRIME_VAL);
    queue_operand(PRIME_VAL + 30'd1);
    queue_operand(PRIME_VAL + 30'd2);
    queue_operand(TOP_VAL - 30'd1);
    queue_operand(TOP_VAL);
    queue_operand(30'h2AAAAAAA);
    queue_operand(30'h15555555);
    queue_operand(30'h20000000);
    queue_operand(30'h00008000);
    queue_operand(30'h3FFF0000);
    queue_operand(30'h0000FFFF);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct = 22;
          receiver_idle_pct = 71;
        end
        1: begin
          sender_idle_pct = 71;
          receiver_idle_pct = 22;
        end
        default: begin
          sender_idle_pct = 0;
          receiver_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        queue_operand(random_operand());
      end
      // The sender holds off until the pipeline has fully emptied.
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_inverses.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_inverses.size()));
    end
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
